// File: rtl/core/bol_pkg.sv
// Shared types and constants for the bounded ordered list.
// Holds the command codes and the controller/datapath interface structs.
// Depends on nothing.
package bol_pkg;

	localparam logic [2:0] CMD_APPEND  = 3'd0;
	localparam logic [2:0] CMD_PREPEND = 3'd1;
	localparam logic [2:0] CMD_POP     = 3'd2;
	localparam logic [2:0] CMD_FIND    = 3'd3;
	localparam logic [2:0] CMD_REMOVE  = 3'd4;
	localparam logic [2:0] CMD_COUNT   = 3'd5;

	typedef struct packed {
		logic append;
		logic prepend;
		logic pop;
		logic ok_set;
		logic ok_clr;
		logic scan_start;
		logic rd_en;
		logic rd_next;
		logic wr_shift;
		logic step;
		logic dec_used;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic match;
		logic last;
		logic next_last;
	} sts_t;

endpackage

// File: rtl/core/bol_ctrl.sv
// Controller state machine for the bounded ordered list.
// Sequences scans, close-up shifts and result delivery; uses bol_pkg.
module bol_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    cmd,
	output logic          out_valid,
	input  logic          out_ready,
	input  bol_pkg::sts_t sts,
	output bol_pkg::ctl_t ctl
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_CMP  = 6'b000100,
		S_SRD  = 6'b001000,
		S_SWR  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q, state_nxt;
	logic   is_remove_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_FIN;
					priority if (cmd == bol_pkg::CMD_APPEND) begin
						ctl.append = !sts.full;
						ctl.ok_set = !sts.full;
						ctl.ok_clr = sts.full;
					end else if (cmd == bol_pkg::CMD_PREPEND) begin
						ctl.prepend = !sts.full;
						ctl.ok_set  = !sts.full;
						ctl.ok_clr  = sts.full;
					end else if (cmd == bol_pkg::CMD_POP) begin
						ctl.pop    = !sts.empty;
						ctl.ok_set = !sts.empty;
						ctl.ok_clr = sts.empty;
					end else if (cmd == bol_pkg::CMD_COUNT) begin
						ctl.ok_set = 1'b1;
					end else if (cmd == bol_pkg::CMD_FIND || cmd == bol_pkg::CMD_REMOVE) begin
						ctl.ok_clr = 1'b1;
						if (!sts.empty) begin
							ctl.scan_start = 1'b1;
							state_nxt      = S_RD;
						end
					end else begin
						ctl.ok_clr = 1'b1;
					end
				end
			end
			S_RD: begin
				ctl.rd_en = 1'b1;
				state_nxt = S_CMP;
			end
			S_CMP: begin
				if (sts.match) begin
					ctl.ok_set = 1'b1;
					if (is_remove_q && !sts.last) begin
						state_nxt = S_SRD;
					end else begin
						ctl.dec_used = is_remove_q;
						state_nxt    = S_FIN;
					end
				end else if (sts.last) begin
					state_nxt = S_FIN;
				end else begin
					ctl.step  = 1'b1;
					state_nxt = S_RD;
				end
			end
			S_SRD: begin
				ctl.rd_en   = 1'b1;
				ctl.rd_next = 1'b1;
				state_nxt   = S_SWR;
			end
			S_SWR: begin
				ctl.wr_shift = 1'b1;
				ctl.step     = 1'b1;
				if (sts.next_last) begin
					ctl.dec_used = 1'b1;
					state_nxt    = S_FIN;
				end else begin
					state_nxt = S_SRD;
				end
			end
			S_FIN: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			is_remove_q <= (cmd == bol_pkg::CMD_REMOVE);
		end
	end

endmodule

// File: rtl/core/bol_dpath.sv
// Datapath for the bounded ordered list: circular entry memory, head and
// fill count, scan index, compare and result register. Uses bol_pkg.
module bol_dpath #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] value,
	input  bol_pkg::ctl_t      ctl,
	output bol_pkg::sts_t      sts,
	output logic               ok,
	output logic [4:0]         count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int UW = $clog2(CAPACITY + 1);
	localparam logic [AW:0]   CAP_S  = (AW + 1)'(CAPACITY);
	localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);
	localparam logic [UW-1:0] CAP_U  = UW'(CAPACITY);

	logic [31:0]   mem [CAPACITY];
	logic [31:0]   rdata_q;
	logic [31:0]   key_q;
	logic [AW-1:0] head_q;
	logic [UW-1:0] used_q;
	logic [AW-1:0] i_q;
	logic          ok_q;
	logic          ok_out_q;
	logic [4:0]    cnt_out_q;

	logic [AW-1:0] head_inc, head_dec, i_p1, tail, phys_i, phys_n;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata;
	logic          we;
	logic [UW:0]   i_ext, u_ext;
	logic [UW+4:0] used_ext;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= CAP_S) begin
			s = s - CAP_S;
		end
		return s[AW-1:0];
	endfunction

	assign head_inc = (head_q == LAST_A) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? LAST_A : head_q - 1'b1;
	assign i_p1     = i_q + 1'b1;
	assign tail     = wrap_add(head_q, used_q[AW-1:0]);
	assign phys_i   = wrap_add(head_q, i_q);
	assign phys_n   = wrap_add(head_q, i_p1);

	assign we    = ctl.append || ctl.prepend || ctl.wr_shift;
	assign waddr = ctl.append ? tail : (ctl.prepend ? head_dec : phys_i);
	assign wdata = ctl.wr_shift ? rdata_q : $unsigned(value);
	assign raddr = ctl.rd_next ? phys_n : phys_i;

	assign i_ext = (UW + 1)'(i_q);
	assign u_ext = (UW + 1)'(used_q);

	assign sts.full      = (used_q == CAP_U);
	assign sts.empty     = (used_q == '0);
	assign sts.match     = (rdata_q == key_q);
	assign sts.last      = (i_ext + (UW + 1)'(1) == u_ext);
	assign sts.next_last = (i_ext + (UW + 1)'(2) == u_ext);

	assign used_ext = (UW + 5)'(used_q);
	assign ok       = ok_out_q;
	assign count    = cnt_out_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			used_q <= '0;
		end else begin
			priority if (ctl.append) begin
				used_q <= used_q + 1'b1;
			end else if (ctl.prepend) begin
				head_q <= head_dec;
				used_q <= used_q + 1'b1;
			end else if (ctl.pop) begin
				head_q <= head_inc;
				used_q <= used_q - 1'b1;
			end else if (ctl.dec_used) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan_start) begin
			key_q <= $unsigned(value);
			i_q   <= '0;
		end else if (ctl.step) begin
			i_q <= i_p1;
		end
		if (ctl.ok_set) begin
			ok_q <= 1'b1;
		end else if (ctl.ok_clr) begin
			ok_q <= 1'b0;
		end
		if (ctl.out_load) begin
			ok_out_q  <= ok_q;
			cnt_out_q <= used_ext[4:0];
		end
	end

endmodule

// File: rtl/core/bounded_ordered_list.sv
// Bounded ordered list. Append, prepend, pop and count pass through FIN to the result register.
// Find and remove read and compare one entry at a time (RD, CMP); remove then moves each later entry
// down one place on close-up (SRD, SWR). One request is in work at a time;
// a new request is taken as soon as the previous result is in the output register.
// Reset clears the count, head pointer and handshake state; entry memory is not cleared.
module bounded_ordered_list #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         cmd,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               ok,
	output logic [4:0]         count
);

	bol_pkg::ctl_t ctl;
	bol_pkg::sts_t sts;

	bol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	bol_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (value),
		.ctl    (ctl),
		.sts    (sts),
		.ok     (ok),
		.count  (count)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("A second request was taken while one is in work.");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.append || ctl.prepend |-> !sts.full)
		else $error("An insert was issued on a full list.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CAPACITY > 31) || (count <= CAPACITY))
		else $error("The reported count exceeds the capacity.");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for bounded_ordered_list: directed table, then random command mix.
// Results are predicted by a queue-based list model, or taken from the directed table for typed rows,
// and compared in order of request. Depends on bol_pkg and the bounded_ordered_list RTL.
module testbench;

	localparam int CAPACITY = 16;
	localparam int PERIOD = 8;
	localparam int RANDOM_ITEMS = 1250;
	localparam int PAUSE_AT_ITEM = 600;
	localparam int HOLD_AT_RESULT = 300;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES = 100;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [2:0] CMD_UNUSED6 = 3'd6;
	localparam logic [2:0] CMD_UNUSED7 = 3'd7;

	typedef struct packed {
		logic       ok;
		logic [4:0] count;
	} outcome_t;

	typedef struct packed {
		logic [2:0]  code;
		logic [31:0] operand;
		logic [4:0]  repeats;
		logic        typed;
		logic        want_ok;
		logic [4:0]  want_count;
	} stim_row_t;

	localparam int N_ROWS = 16;
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		'{bol_pkg::CMD_COUNT,   32'h0000_0000, 5'd1,  1'b1, 1'b1, 5'd0},
		'{bol_pkg::CMD_POP,     32'h0000_0000, 5'd1,  1'b1, 1'b0, 5'd0},
		'{bol_pkg::CMD_FIND,    32'h0000_0000, 5'd1,  1'b1, 1'b0, 5'd0},
		'{bol_pkg::CMD_REMOVE,  32'h0000_0005, 5'd1,  1'b1, 1'b0, 5'd0},
		'{CMD_UNUSED6,          32'hFFFF_FFFF, 5'd1,  1'b1, 1'b0, 5'd0},
		'{CMD_UNUSED7,          32'h0000_0000, 5'd1,  1'b1, 1'b0, 5'd0},
		'{bol_pkg::CMD_PREPEND, 32'h7FFF_FFFF, 5'd1,  1'b0, 1'b0, 5'd0},
		'{bol_pkg::CMD_APPEND,  32'h8000_0000, 5'd1,  1'b0, 1'b0, 5'd0},
		'{bol_pkg::CMD_FIND,    32'h8000_0000, 5'd1,  1'b0, 1'b0, 5'd0},
		'{bol_pkg::CMD_FIND,    32'h0000_0001, 5'd1,  1'b0, 1'b0, 5'd0},
		'{bol_pkg::CMD_APPEND,  32'hFFFF_FFFF, 5'd14, 1'b0, 1'b0, 5'd0},
		'{bol_pkg::CMD_APPEND,  32'h0000_0000, 5'd1,  1'b1, 1'b0, 5'd16},
		'{bol_pkg::CMD_PREPEND, 32'h0000_0001, 5'd1,  1'b1, 1'b0, 5'd16},
		'{bol_pkg::CMD_REMOVE,  32'hFFFF_FFFF, 5'd1,  1'b0, 1'b0, 5'd0},
		'{bol_pkg::CMD_REMOVE,  32'h7FFF_FFFF, 5'd1,  1'b0, 1'b0, 5'd0},
		'{bol_pkg::CMD_POP,     32'h0000_0000, 5'd1,  1'b0, 1'b0, 5'd0}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         cmd = bol_pkg::CMD_COUNT;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               ok;
	logic [4:0]         count;

	logic signed [31:0] held[$];
	outcome_t           pending_outcomes[$];
	int                 mismatches = 0;
	int                 results_seen = 0;
	int                 quiet_cycles = 0;
	bit                 sender_gaps_on = 1'b1;
	bit                 receiver_gaps_on = 1'b1;

	bounded_ordered_list #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ok(ok),
		.count(count)
	);

	always #(PERIOD / 2) clk = ~clk;

	function automatic outcome_t list_apply(input logic [2:0] code, input logic signed [31:0] v);
		outcome_t r;
		int pos;
		r.ok = 1'b0;
		pos = -1;
		for (int i = 0; i < held.size(); i++) begin
			if (pos < 0 && held[i] === v) begin
				pos = i;
			end
		end
		case (code)
			bol_pkg::CMD_APPEND: begin
				if (held.size() < CAPACITY) begin
					held.push_back(v);
					r.ok = 1'b1;
				end
			end
			bol_pkg::CMD_PREPEND: begin
				if (held.size() < CAPACITY) begin
					held.push_front(v);
					r.ok = 1'b1;
				end
			end
			bol_pkg::CMD_POP: begin
				if (held.size() > 0) begin
					void'(held.pop_front());
					r.ok = 1'b1;
				end
			end
			bol_pkg::CMD_FIND: r.ok = (pos >= 0);
			bol_pkg::CMD_REMOVE: begin
				if (pos >= 0) begin
					held.delete(pos);
					r.ok = 1'b1;
				end
			end
			bol_pkg::CMD_COUNT: r.ok = 1'b1;
			default: r.ok = 1'b0;
		endcase
		r.count = 5'(held.size());
		return r;
	endfunction

	function automatic logic signed [31:0] pick_value(input bit prefer_held);
		if (prefer_held && held.size() > 0 && $urandom_range(0, 9) < 7) begin
			return held[$urandom_range(0, held.size() - 1)];
		end
		case ($urandom_range(0, 3))
			0: return $signed(32'($urandom_range(0, 7))) - 32'sd4;
			1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed($urandom);
		endcase
	endfunction

	// The item is accepted at the edge where in_ready is seen high; in_valid stays up until then.
	task automatic send_request(input logic [2:0] code, input logic signed [31:0] v,
		input bit typed, input outcome_t typed_outcome);
		int gap;
		outcome_t predicted;
		gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= code;
		value <= v;
		do @(posedge clk); while (!in_ready);
		predicted = list_apply(code, v);
		pending_outcomes.push_back(typed ? typed_outcome : predicted);
	endtask

	task automatic flag_mismatch(input string what, input outcome_t want);
		if (mismatches < 10) begin
			$display("MISMATCH %s: expected ok=%0d count=%0d, got ok=%0d count=%0d",
				what, want.ok, want.count, ok, count);
		end
		mismatches++;
	endtask

	initial begin
		int gap;
		bit long_hold_done;
		outcome_t want;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && results_seen == HOLD_AT_RESULT) begin
				long_hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if ($urandom_range(0, 39) == 0) begin
					receiver_gaps_on = !receiver_gaps_on;
				end
				gap = receiver_gaps_on ? $urandom_range(0, 6) : 0;
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			results_seen++;
			if (pending_outcomes.size() == 0) begin
				flag_mismatch("unexpected result", '0);
			end else begin
				want = pending_outcomes.pop_front();
				if (ok !== want.ok) begin
					flag_mismatch("field ok", want);
				end
				if (count !== want.count) begin
					flag_mismatch("field count", want);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int phase_left;
		int roll;
		bit growing;
		logic [2:0] code;
		logic signed [31:0] v;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[r]) begin
			for (int k = 0; k < DIRECTED[r].repeats; k++) begin
				send_request(DIRECTED[r].code, $signed(DIRECTED[r].operand), DIRECTED[r].typed,
					{DIRECTED[r].want_ok, DIRECTED[r].want_count});
			end
		end

		growing = 1'b1;
		phase_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				growing = !growing;
				phase_left = $urandom_range(40, 120);
			end
			phase_left--;
			if ($urandom_range(0, 39) == 0) begin
				sender_gaps_on = !sender_gaps_on;
			end
			if (n == PAUSE_AT_ITEM) begin
				in_valid <= 1'b0;
				while (pending_outcomes.size() != 0) @(posedge clk);
			end
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				code = $urandom_range(0, 1) ? CMD_UNUSED6 : CMD_UNUSED7;
			end else if (roll < 10) begin
				code = bol_pkg::CMD_COUNT;
			end else if (roll < 25) begin
				code = bol_pkg::CMD_FIND;
			end else if ((roll < 75) == growing) begin
				code = $urandom_range(0, 1) ? bol_pkg::CMD_APPEND : bol_pkg::CMD_PREPEND;
			end else begin
				code = $urandom_range(0, 1) ? bol_pkg::CMD_POP : bol_pkg::CMD_REMOVE;
			end
			v = pick_value(code == bol_pkg::CMD_FIND || code == bol_pkg::CMD_REMOVE);
			send_request(code, v, 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_outcomes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
